[sv/rlc_rk4_integrator_step_unit_macros.svh]
// assertion helpers shared by the rlc rk4 step unit
`ifndef RLC_RK4_INTEGRATOR_STEP_UNIT_MACROS_SVH
`define RLC_RK4_INTEGRATOR_STEP_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RLCRK4_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rlcrk4 assertion failed");

// next-cycle implication, disabled during reset
`define RLCRK4_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rlcrk4 assertion failed");

`endif

[sv/rlcrk4_pkg.sv]
`timescale 1ns / 1ps
package rlcrk4_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_STEP_SIZE = 2'd0;
   localparam logic [1:0] CSR_STIFFNESS = 2'd1;
   localparam logic [1:0] CSR_DAMPING   = 2'd2;

   localparam logic [31:0] STEP_SIZE_RST = 32'd429497;
   localparam logic [39:0] STIFFNESS_RST = 40'd655360000;
   localparam logic [39:0] DAMPING_RST   = 40'd65536000;

   // micro-op sequence: four stages of four sub-ops, last two ops scale the sums
   localparam logic [1:0] SUB_STIFF   = 2'd0;
   localparam logic [1:0] SUB_DAMP    = 2'd1;
   localparam logic [1:0] SUB_TRIAL_Q = 2'd2;
   localparam logic [1:0] SUB_TRIAL_I = 2'd3;
   localparam logic [3:0] OP_SCALE_Q  = 4'd14;
   localparam logic [3:0] OP_SCALE_I  = 4'd15;
   localparam logic [2:0] DIV_LAST    = 3'd7;

   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   typedef enum logic [1:0] {
      SH_16 = 2'd0,
      SH_32 = 2'd1,
      SH_33 = 2'd2
   } shift_type;

   // controller to datapath commands
   typedef struct packed {
      logic       start;
      logic       load;
      logic       mlo;
      logic       mhi;
      logic       fin;
      logic       apply;
      logic       acc;
      logic       prep;
      logic       div;
      logic       finish;
      logic [3:0] op;
   } cmd_type;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         return a[63] ? S64_MIN : S64_MAX;
      end
      return s;
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] d;
      d = a - b;
      if (a[63] != b[63] && d[63] != a[63]) begin
         return a[63] ? S64_MIN : S64_MAX;
      end
      return d;
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] a);
      return a[63] ? 64'(-a) : 64'(a);
   endfunction

endpackage

[sv/rlcrk4_ctrl.sv]
`timescale 1ns / 1ps
`include "rlc_rk4_integrator_step_unit_macros.svh"
module rlcrk4_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rlcrk4_pkg::cmd_type cmd
);
   import rlcrk4_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_LOAD   = 9'b000000010,
      ST_MLO    = 9'b000000100,
      ST_MHI    = 9'b000001000,
      ST_FIN    = 9'b000010000,
      ST_APPLY  = 9'b000100000,
      ST_ACC    = 9'b001000000,
      ST_DIV    = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] op_ff, op_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       prep_ff, prep_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      prep_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.op       = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               op_in     = '0;
               state_in  = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_MLO;
         end
         ST_MLO: begin
            cmd.mlo  = 1'b1;
            state_in = ST_MHI;
         end
         ST_MHI: begin
            cmd.mhi  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            if (op_ff == OP_SCALE_I) begin
               prep_in  = 1'b1;
               cnt_in   = '0;
               state_in = ST_DIV;
            end else if (op_ff[1:0] == SUB_DAMP && op_ff != OP_SCALE_I) begin
               state_in = ST_ACC;
            end else begin
               op_in    = op_ff + 4'd1;
               state_in = ST_LOAD;
            end
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            op_in    = op_ff + 4'd1;
            state_in = ST_LOAD;
         end
         ST_DIV: begin
            // first cycle loads the dividends, then eight digit steps
            if (prep_ff) begin
               cmd.prep = 1'b1;
            end else begin
               cmd.div = 1'b1;
               cnt_in  = cnt_ff + 3'd1;
               if (cnt_ff == DIV_LAST) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= '0;
         cnt_ff       <= '0;
         prep_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         cnt_ff       <= cnt_in;
         prep_ff      <= prep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `RLCRK4_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && !req_stall,
                       state_ff == ST_LOAD && op_ff == 4'd0)
   `RLCRK4_ASSERT_NEXT(a_div_ends, clock, reset,
                       state_ff == ST_DIV && !prep_ff && cnt_ff == DIV_LAST,
                       state_ff == ST_FINISH)
   `RLCRK4_ASSERT_IMPL(a_acc_after_damp, clock, reset, state_ff == ST_ACC,
                       $past(state_ff == ST_APPLY) && op_ff[1:0] == SUB_DAMP)

endmodule

[sv/rlcrk4_dpath.sv]
`timescale 1ns / 1ps
module rlcrk4_dpath #(
   parameter int STATE_WIDTH = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rlcrk4_pkg::cmd_type           cmd,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [39:0]                   csr_wdata,
   input  logic signed [31:0]            req_drive_start,
   input  logic signed [31:0]            req_drive_mid,
   input  logic signed [31:0]            req_drive_end,
   input  logic                          req_restart,
   output logic signed [STATE_WIDTH-1:0] rsp_charge,
   output logic signed [STATE_WIDTH-1:0] rsp_current
);
   import rlcrk4_pkg::*;

   localparam logic signed [63:0] ST_MAX = (64'sd1 <<< (STATE_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] ST_MIN = -ST_MAX - 64'sd1;

   logic [31:0] step_size_ff;
   logic [39:0] stiffness_ff, damping_ff;

   logic signed [STATE_WIDTH-1:0] charge_ff, current_ff;
   logic signed [STATE_WIDTH-1:0] out_charge_ff, out_current_ff;

   logic signed [63:0] q0_ff, i0_ff, qt_ff, it_ff, kacc_ff, ki_ff, sq_ff, si_ff;
   logic signed [63:0] rq_ff, ri_ff, m_ff;
   logic signed [31:0] vs_ff, vm_ff, ve_ff;

   logic [63:0]  mag_ff;
   logic         neg_ff;
   logic [39:0]  coef_ff;
   shift_type    sh_ff;
   logic [71:0]  plo_ff, phi_ff;

   logic [63:0]  dq_ff, di_ff;
   logic [1:0]   remq_ff, remi_ff;
   logic         sgq_ff, sgi_ff;

   logic [1:0]         sub;
   logic [1:0]         stage;
   logic signed [63:0] src, v_sel;
   logic [39:0]        coef;
   shift_type          sh;
   logic [103:0]       full, shifted;
   logic signed [63:0] m_in;
   logic [63:0]        dq_in, di_in;
   logic [1:0]         remq_in, remi_in;
   logic signed [63:0] newq, newi;

   assign sub   = cmd.op[1:0];
   assign stage = cmd.op[3:2];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff <= STEP_SIZE_RST;
         stiffness_ff <= STIFFNESS_RST;
         damping_ff   <= DAMPING_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STEP_SIZE: step_size_ff <= csr_wdata[31:0];
            CSR_STIFFNESS: stiffness_ff <= csr_wdata;
            CSR_DAMPING:   damping_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // operand, coefficient and shift select for the shared multiplier
   always_comb begin
      src  = qt_ff;
      coef = 40'(step_size_ff);
      sh   = SH_33;
      if (cmd.op == OP_SCALE_Q) begin
         src = sq_ff;
         sh  = SH_32;
      end else if (cmd.op == OP_SCALE_I) begin
         src = si_ff;
         sh  = SH_32;
      end else begin
         unique case (sub)
            SUB_STIFF: begin
               src  = qt_ff;
               coef = stiffness_ff;
               sh   = SH_16;
            end
            SUB_DAMP: begin
               src  = it_ff;
               coef = damping_ff;
               sh   = SH_16;
            end
            SUB_TRIAL_Q: begin
               src = it_ff;
               sh  = (stage == 2'd2) ? SH_32 : SH_33;
            end
            SUB_TRIAL_I: begin
               src = ki_ff;
               sh  = (stage == 2'd2) ? SH_32 : SH_33;
            end
            default: ;
         endcase
      end
   end

   // drive sample for this stage, as q32.32
   always_comb begin
      unique case (stage)
         2'd0:    v_sel = 64'(vs_ff) <<< 16;
         2'd3:    v_sel = 64'(ve_ff) <<< 16;
         default: v_sel = 64'(vm_ff) <<< 16;
      endcase
   end

   // product recombine, shift and saturate
   always_comb begin
      full = {phi_ff, 32'b0} + 104'(plo_ff);
      unique case (sh_ff)
         SH_16:   shifted = full >> 16;
         SH_32:   shifted = full >> 32;
         SH_33:   shifted = full >> 33;
         default: shifted = full >> 16;
      endcase
      if (neg_ff) begin
         if (shifted[103:64] != '0 || shifted[63]) begin
            m_in = S64_MIN;
         end else begin
            m_in = -$signed(shifted[63:0]);
         end
      end else begin
         if (shifted[103:64] != '0 || shifted[63]) begin
            m_in = S64_MAX;
         end else begin
            m_in = $signed(shifted[63:0]);
         end
      end
   end

   // divide by three, eight quotient bits a cycle on both lanes
   always_comb begin
      logic [2:0] t;
      dq_in   = dq_ff;
      di_in   = di_ff;
      remq_in = remq_ff;
      remi_in = remi_ff;
      for (int k = 0; k < 8; k++) begin
         t     = {remq_in, dq_in[63]};
         dq_in = {dq_in[62:0], 1'b0};
         if (t >= 3'd3) begin
            remq_in  = 2'(t - 3'd3);
            dq_in[0] = 1'b1;
         end else begin
            remq_in = t[1:0];
         end
         t     = {remi_in, di_in[63]};
         di_in = {di_in[62:0], 1'b0};
         if (t >= 3'd3) begin
            remi_in  = 2'(t - 3'd3);
            di_in[0] = 1'b1;
         end else begin
            remi_in = t[1:0];
         end
      end
   end

   // state update with saturation to the state range
   always_comb begin
      logic signed [63:0] incq, inci;
      incq = sgq_ff ? -$signed(dq_ff) : $signed(dq_ff);
      inci = sgi_ff ? -$signed(di_ff) : $signed(di_ff);
      newq = sat_add(q0_ff, incq);
      newi = sat_add(i0_ff, inci);
      if (newq > ST_MAX) begin
         newq = ST_MAX;
      end else if (newq < ST_MIN) begin
         newq = ST_MIN;
      end
      if (newi > ST_MAX) begin
         newi = ST_MAX;
      end else if (newi < ST_MIN) begin
         newi = ST_MIN;
      end
   end

   // integrator state
   always_ff @(posedge clock) begin
      if (reset) begin
         charge_ff  <= '0;
         current_ff <= '0;
      end else if (cmd.finish) begin
         charge_ff  <= newq[STATE_WIDTH-1:0];
         current_ff <= newi[STATE_WIDTH-1:0];
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         vs_ff <= req_drive_start;
         vm_ff <= req_drive_mid;
         ve_ff <= req_drive_end;
         q0_ff <= req_restart ? 64'sd0 : 64'(charge_ff);
         i0_ff <= req_restart ? 64'sd0 : 64'(current_ff);
         qt_ff <= req_restart ? 64'sd0 : 64'(charge_ff);
         it_ff <= req_restart ? 64'sd0 : 64'(current_ff);
      end
      if (cmd.load) begin
         mag_ff  <= mag64(src);
         neg_ff  <= src[63];
         coef_ff <= coef;
         sh_ff   <= sh;
      end
      if (cmd.mlo) begin
         plo_ff <= mag_ff[31:0] * coef_ff;
      end
      if (cmd.mhi) begin
         phi_ff <= mag_ff[63:32] * coef_ff;
      end
      if (cmd.fin) begin
         m_ff <= m_in;
      end
      if (cmd.apply) begin
         if (cmd.op == OP_SCALE_Q) begin
            rq_ff <= m_ff;
         end else if (cmd.op == OP_SCALE_I) begin
            ri_ff <= m_ff;
         end else begin
            unique case (sub)
               SUB_STIFF:   kacc_ff <= sat_sub(v_sel, m_ff);
               SUB_DAMP:    ki_ff   <= sat_sub(kacc_ff, m_ff);
               SUB_TRIAL_Q: qt_ff   <= sat_add(q0_ff, m_ff);
               SUB_TRIAL_I: it_ff   <= sat_add(i0_ff, m_ff);
               default: ;
            endcase
         end
      end
      // weighted slope sums, middle stages count twice
      if (cmd.acc) begin
         unique case (stage)
            2'd0: begin
               sq_ff <= it_ff;
               si_ff <= ki_ff;
            end
            2'd3: begin
               sq_ff <= sat_add(sq_ff, it_ff);
               si_ff <= sat_add(si_ff, ki_ff);
            end
            default: begin
               sq_ff <= sat_add(sat_add(sq_ff, it_ff), it_ff);
               si_ff <= sat_add(sat_add(si_ff, ki_ff), ki_ff);
            end
         endcase
      end
      // divide by six as halving then dividing by three
      if (cmd.prep) begin
         dq_ff   <= mag64(rq_ff) >> 1;
         di_ff   <= mag64(ri_ff) >> 1;
         sgq_ff  <= rq_ff[63];
         sgi_ff  <= ri_ff[63];
         remq_ff <= '0;
         remi_ff <= '0;
      end else if (cmd.div) begin
         dq_ff   <= dq_in;
         di_ff   <= di_in;
         remq_ff <= remq_in;
         remi_ff <= remi_in;
      end
      if (cmd.finish) begin
         out_charge_ff  <= newq[STATE_WIDTH-1:0];
         out_current_ff <= newi[STATE_WIDTH-1:0];
      end
   end

   assign rsp_charge  = out_charge_ff;
   assign rsp_current = out_current_ff;

endmodule

[sv/rlc_rk4_integrator_step_unit.sv]
`timescale 1ns / 1ps
// one rk4 step of a driven series rlc circuit per word
// one word at a time: req_stall stays high from the accepted word until the result is
// written back, as sixteen dependent multiplies, each as two 32x40 partial products,
// four accumulate steps, a divide by six and a write-back that waits out receiver stalls
// reset: charge and current clear to zero, registers return to their defaults
module rlc_rk4_integrator_step_unit #(
   parameter int STATE_WIDTH = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [31:0]            req_drive_start,
   input  logic signed [31:0]            req_drive_mid,
   input  logic signed [31:0]            req_drive_end,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [STATE_WIDTH-1:0] rsp_charge,
   output logic signed [STATE_WIDTH-1:0] rsp_current,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [39:0]                   csr_wdata
);
   import rlcrk4_pkg::*;

   cmd_type cmd;

   // sequencer
   rlcrk4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // arithmetic and state
   rlcrk4_dpath #(
      .STATE_WIDTH (STATE_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_drive_start (req_drive_start),
      .req_drive_mid   (req_drive_mid),
      .req_drive_end   (req_drive_end),
      .req_restart     (req_restart),
      .rsp_charge      (rsp_charge),
      .rsp_current     (rsp_current)
   );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
   import rlcrk4_pkg::*;

   localparam int          STATE_WIDTH = 48;
   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          DRAIN_CYCLES = 120;
   localparam int          HOLD_CYCLES = 400;
   localparam logic [1:0]  CSR_UNMAPPED = 2'd3;
   localparam logic signed [63:0] Q_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] Q_MIN = -64'sh0000_7FFF_FFFF_FFFF - 64'sd1;

   typedef struct {
      logic signed [STATE_WIDTH-1:0] charge;
      logic signed [STATE_WIDTH-1:0] current;
   } state_word;

   typedef struct {
      logic signed [31:0]            v_start;
      logic signed [31:0]            v_mid;
      logic signed [31:0]            v_end;
      logic                          restart;
      logic                          typed;
      logic signed [STATE_WIDTH-1:0] charge;
      logic signed [STATE_WIDTH-1:0] current;
   } drive_row;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [31:0]            req_drive_start;
   logic signed [31:0]            req_drive_mid;
   logic signed [31:0]            req_drive_end;
   logic                          req_restart;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [STATE_WIDTH-1:0] rsp_charge;
   logic signed [STATE_WIDTH-1:0] rsp_current;
   logic                          csr_we;
   logic [1:0]                    csr_index;
   logic [39:0]                   csr_wdata;

   // predictor copy of registers and state
   logic [31:0]        step_h;
   logic [39:0]        coef_stiff;
   logic [39:0]        coef_damp;
   logic signed [63:0] q_now;
   logic signed [63:0] i_now;

   state_word expected_states[$];
   int        mismatches = 0;
   int        words_in;
   int        words_out = 0;
   int        idle_cycles = 0;
   int        send_idle_pct;
   int        stall_pct;
   logic      hold_req;

   rlc_rk4_integrator_step_unit #(.STATE_WIDTH(STATE_WIDTH)) DUT (.*);

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic signed [63:0] add_clip(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         s = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      end
      return s;
   endfunction

   function automatic logic signed [63:0] sub_clip(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic signed [63:0] d;
      d = a - b;
      if (a[63] != b[63] && d[63] != a[63]) begin
         d = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      end
      return d;
   endfunction

   // sign * trunc(|a| * c >> sh), clipped to 64 bits
   function automatic logic signed [63:0] scale(input logic signed [63:0] a,
                                                input logic [39:0] c, input int sh);
      logic [63:0]  mag;
      logic [127:0] p;
      logic signed [63:0] r;
      mag = a[63] ? (~a + 64'd1) : a;
      p = ({64'b0, mag} * {88'b0, c}) >> sh;
      if (a[63]) begin
         if (p >= (128'd1 << 63)) r = {1'b1, 63'b0};
         else r = -$signed(p[63:0]);
      end else begin
         if (p >= (128'd1 << 63)) r = {1'b0, {63{1'b1}}};
         else r = $signed(p[63:0]);
      end
      return r;
   endfunction

   function automatic logic signed [63:0] current_slope(input logic signed [63:0] q,
                                                        input logic signed [63:0] i,
                                                        input logic signed [63:0] v);
      return sub_clip(sub_clip(v, scale(q, coef_stiff, 16)), scale(i, coef_damp, 16));
   endfunction

   function automatic logic signed [63:0] rk4_update(input logic signed [63:0] base,
                                                     input logic signed [63:0] k1,
                                                     input logic signed [63:0] k2,
                                                     input logic signed [63:0] k3,
                                                     input logic signed [63:0] k4);
      logic signed [63:0] s;
      logic signed [63:0] r;
      s = add_clip(add_clip(add_clip(add_clip(add_clip(k1, k2), k2), k3), k3), k4);
      r = add_clip(base, scale(s, {8'b0, step_h}, 32) / 64'sd6);
      if (r > Q_MAX) r = Q_MAX;
      if (r < Q_MIN) r = Q_MIN;
      return r;
   endfunction

   // one rk4 step on the predictor state
   task automatic rk4_predict(input logic signed [31:0] vs_in, input logic signed [31:0] vm_in,
                              input logic signed [31:0] ve_in, input logic restart,
                              output state_word res);
      logic signed [63:0] vs, vm, ve, q0, i0, q, i;
      logic signed [63:0] kq1, ki1, kq2, ki2, kq3, ki3, kq4, ki4;
      logic [39:0]        h;
      vs = {{16{vs_in[31]}}, vs_in, 16'b0};
      vm = {{16{vm_in[31]}}, vm_in, 16'b0};
      ve = {{16{ve_in[31]}}, ve_in, 16'b0};
      h = {8'b0, step_h};
      if (restart) begin
         q_now = 0;
         i_now = 0;
      end
      q0 = q_now;
      i0 = i_now;
      kq1 = i0;
      ki1 = current_slope(q0, i0, vs);
      q = add_clip(q0, scale(kq1, h, 33));
      i = add_clip(i0, scale(ki1, h, 33));
      kq2 = i;
      ki2 = current_slope(q, i, vm);
      q = add_clip(q0, scale(kq2, h, 33));
      i = add_clip(i0, scale(ki2, h, 33));
      kq3 = i;
      ki3 = current_slope(q, i, vm);
      q = add_clip(q0, scale(kq3, h, 32));
      i = add_clip(i0, scale(ki3, h, 32));
      kq4 = i;
      ki4 = current_slope(q, i, ve);
      q_now = rk4_update(q0, kq1, kq2, kq3, kq4);
      i_now = rk4_update(i0, ki1, ki2, ki3, ki4);
      res.charge = q_now[STATE_WIDTH-1:0];
      res.current = i_now[STATE_WIDTH-1:0];
   endtask

   // register write, only while the block is idle
   task automatic csr_write(input logic [1:0] idx, input logic [39:0] data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_STEP_SIZE: step_h = data[31:0];
         CSR_STIFFNESS: coef_stiff = data;
         CSR_DAMPING:   coef_damp = data;
         default: ;
      endcase
   endtask

   // offer one word and record its expected state
   task automatic send_word(input drive_row w);
      state_word res;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_drive_start = w.v_start;
      req_drive_mid = w.v_mid;
      req_drive_end = w.v_end;
      req_restart = w.restart;
      do @(posedge clock); while (req_stall);
      rk4_predict(w.v_start, w.v_mid, w.v_end, w.restart, res);
      if (w.typed) begin
         res.charge = w.charge;
         res.current = w.current;
      end
      expected_states.push_back(res);
      words_in++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (expected_states.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_drive();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) return $signed($urandom_range(1 << 20)) - 32'sd524288;
      if (pick < 85) return $signed($urandom);
      if (pick < 92) return 32'sh7FFF_FFFF;
      return 32'sh8000_0000;
   endfunction

   // receiver: random stalls plus one long hold on request
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            repeat (HOLD_CYCLES) begin
               rsp_stall = 1'b1;
               @(negedge clock);
            end
         end
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      state_word exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_out++;
         if (expected_states.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: charge %h current %h",
                                           rsp_charge, rsp_current);
         end else begin
            exp_w = expected_states.pop_front();
            if (exp_w.charge !== rsp_charge || exp_w.current !== rsp_current) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch word %0d: charge exp %h got %h, current exp %h got %h",
                           words_out, exp_w.charge, rsp_charge, exp_w.current, rsp_current);
            end
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", idle_cycles);
            $display("** rlc_rk4_integrator_step_unit: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      drive_row dir_tab[12];
      drive_row w;
      int phase;
      reset = 1'b1;
      req_valid = 1'b0;
      req_drive_start = '0;
      req_drive_mid = '0;
      req_drive_end = '0;
      req_restart = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_STEP_SIZE;
      csr_wdata = '0;
      hold_req = 1'b0;
      words_in = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      step_h = STEP_SIZE_RST;
      coef_stiff = STIFFNESS_RST;
      coef_damp = DAMPING_RST;
      q_now = 0;
      i_now = 0;

      // directed words: zero drive after restart always gives zero state
      dir_tab[0]  = '{32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1, '0, '0};
      dir_tab[1]  = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 1'b0, '0, '0};
      dir_tab[2]  = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 1'b0, '0, '0};
      dir_tab[3]  = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b0, '0, '0};
      dir_tab[4]  = '{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b1, 1'b0, '0, '0};
      dir_tab[5]  = '{32'sd1, -32'sd1, 32'sd0, 1'b0, 1'b0, '0, '0};
      dir_tab[6]  = '{32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1, '0, '0};
      dir_tab[7]  = '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_F0F0, 1'b0, 1'b0, '0, '0};
      dir_tab[8]  = '{32'shAAAA_AAAA, 32'sh5555_5555, 32'shF0F0_0F0F, 1'b0, 1'b0, '0, '0};
      dir_tab[9]  = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b0, '0, '0};
      dir_tab[10] = '{-32'sh0001_0000, 32'sd0, 32'sh0001_0000, 1'b0, 1'b0, '0, '0};
      dir_tab[11] = '{32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1, '0, '0};

      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      for (int r = 0; r < 12; r++) send_word(dir_tab[r]);

      for (phase = 0; phase < 8; phase++) begin
         wait_drained();
         // register settings per phase, extremes included
         case (phase)
            0: ;
            1: begin
               csr_write(CSR_STEP_SIZE, 40'hFF_FFFF_FFFF);
               csr_write(CSR_STIFFNESS, 40'd0);
               csr_write(CSR_DAMPING, 40'd0);
            end
            2: begin
               csr_write(CSR_STEP_SIZE, 40'd0);
               csr_write(CSR_UNMAPPED, 40'h12_3456_789A);
            end
            3: begin
               csr_write(CSR_STEP_SIZE, {8'hA5, STEP_SIZE_RST});
               csr_write(CSR_STIFFNESS, 40'hFF_FFFF_FFFF);
               csr_write(CSR_DAMPING, 40'hFF_FFFF_FFFF);
            end
            4, 5: begin
               csr_write(CSR_STEP_SIZE, {8'd0, $urandom});
               csr_write(CSR_STIFFNESS, {8'($urandom_range(255)), $urandom});
               csr_write(CSR_DAMPING, {8'($urandom_range(255)), $urandom});
            end
            default: begin
               csr_write(CSR_STEP_SIZE, {8'd0, $urandom_range(1 << 24)});
               csr_write(CSR_STIFFNESS, {8'd0, $urandom_range(1 << 30)});
               csr_write(CSR_DAMPING, {8'd0, $urandom_range(1 << 28)});
            end
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 72; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 72; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
         endcase
         // restart after the register change, zero drive gives zero state
         send_word(dir_tab[0]);
         for (int n = 0; n < 124; n++) begin
            if (phase == 1 && n == 10) hold_req = 1'b1;
            if (phase == 2 && n == 60) wait_drained();
            w.v_start = rand_drive();
            w.v_mid = rand_drive();
            w.v_end = rand_drive();
            w.restart = ($urandom_range(99) < 5);
            w.typed = 1'b0;
            w.charge = '0;
            w.current = '0;
            send_word(w);
         end
      end

      wait_drained();
      $display("sent %0d words over eight register settings (defaults, extremes, zero step)",
               words_in);
      $display("checked %0d results under sender gaps, receiver stalls and a long hold",
               words_out);
      if (mismatches == 0) begin
         $display("** rlc_rk4_integrator_step_unit: PASSED **");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("** rlc_rk4_integrator_step_unit: FAILED **");
      end
      $finish;
   end

endmodule
